// ----- src/wfp_pkg.sv -----
// Package for the wall-follow PID block: field widths, register indexes and reset values.
package wfp_pkg;

  localparam int GAIN_FRAC_BITS = 12;
  localparam int ACC_BITS       = 32;

  localparam int RANGE_W  = 14;
  localparam int ERR_W    = 15;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 10;
  localparam int ANG_W    = 16;

  localparam int IN_FIELDS_W  = 6 * RANGE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ANG_W + SPEED_W + ERR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_DISTANCE = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_GAIN_I        = 3'd3,
    REG_CRUISE_SPEED  = 3'd4
  } cfg_reg_t;

  localparam logic [RANGE_W-1:0] WALL_DISTANCE_RST = 14'd500;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 16'd819;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 16'd12288;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST        = 16'd20;
  localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST  = 10'd5;

endpackage

// ----- src/wall_follow_pid_top.sv -----
// Wall-follow PID steering: side minimum, error, saturating integral, PID sum, saturation.
// The word passes through the input, error, multiply, sum/round and output registers.
// Throughput: one word per cycle unless the output stalls; the integral and previous
//   error update in the error stage, so back-to-back words need no bubble. Ready
//   ripples back through all stages.
// Reset (rst, synchronous) empties the pipeline, clears the PID state, loads defaults.
module wall_follow_pid_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [wfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wfp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // left_range_a, left_range_b, left_range_c, right_range_a, right_range_b,
  // right_range_c, then zero fill
  input  logic [wfp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // follow_left
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ang_vel, lin_vel, wall_error, then zero fill
  output logic [wfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // clipped
  output logic                               m_axis_tuser
);
  import wfp_pkg::*;

  localparam int TP_W  = GAIN_W + 1 + ERR_W;
  localparam int TD_W  = GAIN_W + 1 + DIFF_W;
  localparam int TI_W  = GAIN_W + 1 + ACC_BITS;
  localparam int SUM_W = TI_W + 2;
  localparam int Q_W   = SUM_W - GAIN_FRAC_BITS;
  localparam logic [SUM_W-1:0] ROUND_HALF =
    {{(SUM_W-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);

  // configuration
  logic [RANGE_W-1:0] wall_distance;
  logic [GAIN_W-1:0]  gain_p, gain_d, gain_i;
  logic [SPEED_W-1:0] cruise_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_distance <= WALL_DISTANCE_RST;
      gain_p        <= GAIN_P_RST;
      gain_d        <= GAIN_D_RST;
      gain_i        <= GAIN_I_RST;
      cruise_speed  <= CRUISE_SPEED_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_WALL_DISTANCE: wall_distance <= cfg_data[RANGE_W-1:0];
        REG_GAIN_P:        gain_p        <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:        gain_d        <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:        gain_i        <= cfg_data[GAIN_W-1:0];
        REG_CRUISE_SPEED:  cruise_speed  <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v0, v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4          = !v4 || m_axis_tready;
  assign rdy3          = !v3 || rdy4;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = !v0 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (s_axis_tready) v0 <= s_axis_tvalid;
      if (rdy1)          v1 <= v0;
      if (rdy2)          v2 <= v1;
      if (rdy3)          v3 <= v2;
      if (rdy4)          v4 <= v3;
    end
  end

  // input register
  logic [IN_FIELDS_W-1:0] in_ranges;
  logic                   in_left;

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_ranges <= s_axis_tdata[IN_FIELDS_W-1:0];
      in_left   <= s_axis_tuser;
    end
  end

  // error stage: side minimum, error, derivative, saturating integral
  logic [RANGE_W-1:0]        ra, rb, rc, rab, side_min;
  logic signed [ERR_W-1:0]   e_calc;
  logic signed [DIFF_W-1:0]  de_calc;
  logic signed [ACC_BITS:0]  sum_wide;
  logic signed [ACC_BITS-1:0] sum_calc;
  logic                      sum_ovf;

  logic signed [ERR_W-1:0]    last_error;
  logic signed [ACC_BITS-1:0] error_sum;
  logic                       have_last;

  always_comb begin
    if (in_left) begin
      ra = in_ranges[RANGE_W-1:0];
      rb = in_ranges[2*RANGE_W-1:RANGE_W];
      rc = in_ranges[3*RANGE_W-1:2*RANGE_W];
    end else begin
      ra = in_ranges[4*RANGE_W-1:3*RANGE_W];
      rb = in_ranges[5*RANGE_W-1:4*RANGE_W];
      rc = in_ranges[6*RANGE_W-1:5*RANGE_W];
    end
    rab      = (rb < ra) ? rb : ra;
    side_min = (rc < rab) ? rc : rab;
    e_calc   = $signed({1'b0, side_min}) - $signed({1'b0, wall_distance});
    de_calc  = have_last ? ({e_calc[ERR_W-1], e_calc} - {last_error[ERR_W-1], last_error})
                         : '0;
    sum_wide = {error_sum[ACC_BITS-1], error_sum}
             + {{(ACC_BITS+1-ERR_W){e_calc[ERR_W-1]}}, e_calc};
    sum_ovf  = sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1];
    if (sum_ovf)
      sum_calc = sum_wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                    : {1'b0, {(ACC_BITS-1){1'b1}}};
    else
      sum_calc = sum_wide[ACC_BITS-1:0];
  end

  logic signed [ERR_W-1:0]    s1_e;
  logic signed [DIFF_W-1:0]   s1_de;
  logic signed [ACC_BITS-1:0] s1_sum;
  logic                       s1_clip;

  logic adv1;
  assign adv1 = v0 && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      have_last  <= 1'b0;
    end else if (adv1) begin
      last_error <= e_calc;
      error_sum  <= sum_calc;
      have_last  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_e    <= e_calc;
      s1_de   <= de_calc;
      s1_sum  <= sum_calc;
      s1_clip <= sum_ovf;
    end
  end

  // multiply stage
  logic signed [TP_W-1:0]  s2_tp;
  logic signed [TD_W-1:0]  s2_td;
  logic signed [TI_W-1:0]  s2_ti;
  logic signed [ERR_W-1:0] s2_e;
  logic                    s2_clip;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_tp   <= $signed({1'b0, gain_p}) * s1_e;
      s2_td   <= $signed({1'b0, gain_d}) * s1_de;
      s2_ti   <= $signed({1'b0, gain_i}) * s1_sum;
      s2_e    <= s1_e;
      s2_clip <= s1_clip;
    end
  end

  // negated sum plus half an LSB
  logic [SUM_W-1:0]        acc_calc;
  logic [SUM_W-1:0]        s3_acc;
  logic signed [ERR_W-1:0] s3_e;
  logic                    s3_clip;

  assign acc_calc = ROUND_HALF
                  - {{(SUM_W-TP_W){s2_tp[TP_W-1]}}, s2_tp}
                  - {{(SUM_W-TD_W){s2_td[TD_W-1]}}, s2_td}
                  - {{(SUM_W-TI_W){s2_ti[TI_W-1]}}, s2_ti};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_acc  <= acc_calc;
      s3_e    <= s2_e;
      s3_clip <= s2_clip;
    end
  end

  // floor shift and saturation into the output register
  logic [Q_W-1:0]         q;
  logic [Q_W-ANG_W:0]     q_hi;
  logic                   ang_ovf;
  logic [ANG_W-1:0]       ang_calc;

  always_comb begin
    q       = s3_acc[SUM_W-1:GAIN_FRAC_BITS];
    q_hi    = q[Q_W-1:ANG_W-1];
    ang_ovf = !((&q_hi) || !(|q_hi));
    if (ang_ovf)
      ang_calc = q[Q_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    else
      ang_calc = q[ANG_W-1:0];
  end

  logic [ANG_W-1:0] out_ang;
  logic [ERR_W-1:0] out_err;
  logic             out_clip;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_ang  <= ang_calc;
      out_err  <= s3_e;
      out_clip <= s3_clip || ang_ovf;
    end
  end

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_err, cruise_speed, out_ang};
  assign m_axis_tuser  = out_clip;

`ifndef SYNTHESIS
  // error is a difference of two 14-bit values and never reaches the most negative code
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_err != {1'b1, {(ERR_W-1){1'b0}}}))
    else $error("wall_error outside the reachable range");

  // the integral moves only when a word enters the error stage
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !adv1) |=> $stable(error_sum))
    else $error("error_sum changed without a word");

  // once a sample has been taken the derivative stays enabled until reset
  a_have_last: assert property (@(posedge clk) disable iff (rst)
    (!rst && have_last) |=> have_last)
    else $error("first-sample flag dropped");
`endif

endmodule
